// ===== sv/double_hash_server_placement_unit_macros.svh =====
// Assertion macros shared by the placement unit.
`ifndef DOUBLE_HASH_SERVER_PLACEMENT_UNIT_MACROS_SVH
`define DOUBLE_HASH_SERVER_PLACEMENT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dhsp assertion failed");
`define DHSP_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dhsp forbidden condition seen");
`else
`define DHSP_ASSERT(lbl, clk, rst, prop)
`define DHSP_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== sv/dhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhsp_pkg
// Types and constants shared by the double hash server placement unit.
// ----------------------------------------------------------------------------
package dhsp_pkg;
   localparam int MAX_SERVERS = 1024;
   localparam int SLOT_LIMIT  = 32;
   localparam int SRV_W       = $clog2(MAX_SERVERS);
   localparam int CNT_W       = SRV_W + 1;
   localparam int OCC_W       = 6;
   localparam int SLOT_W      = 5;
   localparam int HASH_W      = 32;
   localparam int BIT_CNT_W   = $clog2(HASH_W);

   localparam logic [7:0]  SPACE_CHAR = 8'h20;
   localparam logic [31:0] HOME_MULT  = 32'd7919;
   localparam logic [31:0] STEP_MULT  = 32'd104729;
   localparam logic [31:0] STEP_ADD   = 32'd123;

   localparam logic [1:0] CSR_SERVER_COUNT    = 2'd0;
   localparam logic [1:0] CSR_SERVER_CAPACITY = 2'd1;

   localparam logic STATUS_PLACED  = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [SRV_W-1:0]  placed_server;
      logic [SRV_W-1:0]  home_server;
      logic [SLOT_W-1:0] slot_taken;
      logic              moved;
      logic              status;
   } rsp_type;

   // Handoff from the front queue to the back end.
   typedef struct packed {
      logic       valid;
      logic [7:0] checksum;
   } job_type;

   typedef struct packed {
      logic [CNT_W-1:0] server_count;
      logic [OCC_W-1:0] capacity;
   } cfg_type;
endpackage

// ===== sv/dhsp_ram.sv =====
// ----------------------------------------------------------------------------
// dhsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dhsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/dhsp_front.sv =====
// ----------------------------------------------------------------------------
// dhsp_front
// Folds characters into the checksum and queues finished requests.
// ----------------------------------------------------------------------------
module dhsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dhsp_pkg::req_type req_data,
   input  logic             clearing,
   output dhsp_pkg::job_type job,
   input  logic             job_pop
);
   logic [7:0] csum_ff, csum_in, csum_next;
   logic [7:0] q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       accept, push, pop;

   assign req_stall = clearing || (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign csum_next = (req_data.char_code != dhsp_pkg::SPACE_CHAR) ?
                      (csum_ff ^ req_data.char_code) : csum_ff;
   assign push      = accept && req_data.last_char;
   assign pop       = job_pop && (count_ff != 2'd0);

   always_comb begin
      csum_in = csum_ff;
      if (accept) begin
         csum_in = req_data.last_char ? 8'd0 : csum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_ff   <= 8'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         csum_ff <= csum_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= csum_next;
      end
   end

   assign job.valid    = (count_ff != 2'd0);
   assign job.checksum = q_ff[rd_ptr_ff];
endmodule

// ===== sv/dhsp_back.sv =====
// ----------------------------------------------------------------------------
// dhsp_back
// Probes servers by double hashing and updates the occupancy memory.
// ----------------------------------------------------------------------------
`include "double_hash_server_placement_unit_macros.svh"
module dhsp_back (
   input  logic              clock,
   input  logic              reset,
   input  dhsp_pkg::cfg_type cfg,
   input  dhsp_pkg::job_type job,
   output logic              job_pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dhsp_pkg::rsp_type rsp_data
);
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_HOLD  = 7'b1000000
   } state_type;

   localparam int SW = dhsp_pkg::SRV_W;
   localparam int CW = dhsp_pkg::CNT_W;
   localparam int OW = dhsp_pkg::OCC_W;

   state_type state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [31:0]   addr_ff, addr_in, step_ff, step_in, sh_ff, sh_in;
   logic [dhsp_pkg::BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [SW-1:0] rem_ff, rem_in, srv_ff, srv_in, home_ff, home_in, idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dhsp_pkg::rsp_type rsp_ff, rsp_in, res_ff, res_in;

   logic [CW-1:0] n_eff;
   logic [OW-1:0] cap_eff;
   logic [SW:0]   trial;
   logic          out_free;
   logic          ram_we;
   logic [SW-1:0] ram_waddr, ram_raddr;
   logic [OW-1:0] ram_wdata, occ;

   always_comb begin
      if (cfg.server_count == '0) begin
         n_eff = CW'(1);
      end else if (cfg.server_count > CW'(dhsp_pkg::MAX_SERVERS)) begin
         n_eff = CW'(dhsp_pkg::MAX_SERVERS);
      end else begin
         n_eff = cfg.server_count;
      end
      cap_eff = (cfg.capacity > OW'(dhsp_pkg::SLOT_LIMIT)) ?
                OW'(dhsp_pkg::SLOT_LIMIT) : cfg.capacity;
   end

   assign trial    = {rem_ff, sh_ff[31]};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      sh_in        = sh_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      srv_in       = srv_ff;
      home_in      = home_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = srv_ff;
      ram_wdata    = occ + OW'(1);
      ram_raddr    = srv_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SW'(1);
            if (clr_ff == SW'(dhsp_pkg::MAX_SERVERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job.valid) begin
               job_pop  = 1'b1;
               addr_in  = 32'(job.checksum) * dhsp_pkg::HOME_MULT;
               step_in  = 32'(job.checksum) * dhsp_pkg::STEP_MULT + dhsp_pkg::STEP_ADD;
               sh_in    = 32'(job.checksum) * dhsp_pkg::HOME_MULT;
               bit_in   = '0;
               rem_in   = '0;
               idx_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            sh_in  = {sh_ff[30:0], 1'b0};
            rem_in = (trial >= n_eff) ? SW'(trial - n_eff) : trial[SW-1:0];
            bit_in = bit_ff + 1'b1;
            if (bit_ff == '1) begin
               srv_in   = rem_in;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (idx_ff == '0) begin
               home_in = srv_ff;
            end
            res_in.home_server = (idx_ff == '0) ? srv_ff : home_ff;
            if (occ < cap_eff) begin
               ram_we               = 1'b1;
               res_in.placed_server = srv_ff;
               res_in.slot_taken    = occ[dhsp_pkg::SLOT_W-1:0];
               res_in.moved         = (srv_ff != res_in.home_server);
               res_in.status        = dhsp_pkg::STATUS_PLACED;
               state_in             = ST_OUT;
            end else if (CW'(idx_ff) == n_eff - CW'(1)) begin
               res_in.placed_server = '0;
               res_in.slot_taken    = '0;
               res_in.moved         = 1'b0;
               res_in.status        = dhsp_pkg::STATUS_DROPPED;
               state_in             = ST_OUT;
            end else begin
               idx_in   = idx_ff + SW'(1);
               addr_in  = addr_ff + step_ff;
               sh_in    = addr_ff + step_ff;
               bit_in   = '0;
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      step_ff <= step_in;
      sh_ff   <= sh_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      srv_ff  <= srv_in;
      home_ff <= home_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   dhsp_ram #(
      .WIDTH(OW),
      .DEPTH(dhsp_pkg::MAX_SERVERS)
   ) u_occ_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(occ)
   );

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DHSP_ASSERT(a_place_only_below_cap, clock, reset, (ram_we && state_ff == ST_CHECK) |-> (occ < cap_eff))
   `DHSP_ASSERT(a_probe_in_range, clock, reset, (state_ff == ST_DIV) |-> (CW'(idx_ff) < n_eff))
   `DHSP_ASSERT(a_server_in_range, clock, reset, (state_ff == ST_READ) |-> (CW'(srv_ff) < n_eff))
   `DHSP_NEVER(a_no_pop_while_busy, clock, reset, job_pop && state_ff != ST_IDLE)
endmodule

// ===== sv/double_hash_server_placement_unit.sv =====
// ----------------------------------------------------------------------------
// double_hash_server_placement_unit
// Places requests on servers by double hashing over an occupancy table.
// ----------------------------------------------------------------------------
// Characters of a request arrive one per transaction; every non-space
// character is XORed into an 8-bit checksum, and the transaction flagged as
// the last character queues the request for placement. Character
// transactions are taken one per cycle while the two-entry request queue has
// room and the occupancy memory is not being cleared. Placement probes
// servers along the double-hash sequence; each probe reduces the address
// modulo the server count one address bit at a time in the shared remainder
// unit, then reads the occupancy memory and checks it. After reset the
// occupancy memory is cleared, one entry per cycle, through all 1024
// entries; req_stall stays high during that pass while configuration
// writes are still taken. Register index 0 sets the server count, index 1
// the per-server capacity; csr_ready is always high.
module double_hash_server_placement_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dhsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dhsp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [10:0]       csr_data
);
   dhsp_pkg::cfg_type cfg_ff, cfg_in;
   dhsp_pkg::job_type job;
   logic job_pop, clearing;

   // Configuration registers; writes to unknown indexes are ignored.
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dhsp_pkg::CSR_SERVER_COUNT:    cfg_in.server_count = csr_data;
            dhsp_pkg::CSR_SERVER_CAPACITY: cfg_in.capacity     = csr_data[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_count <= dhsp_pkg::CNT_W'(1);
         cfg_ff.capacity     <= dhsp_pkg::OCC_W'(dhsp_pkg::SLOT_LIMIT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: checksum and request queue.
   dhsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .clearing (clearing),
      .job      (job),
      .job_pop  (job_pop)
   );

   // Back end: probing, occupancy update and the result register.
   dhsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (job),
      .job_pop  (job_pop),
      .clearing (clearing),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );
endmodule
